### rtl/lvpi_pkg.sv
`timescale 1ns / 1ps
package lvpi_pkg;

    localparam int CB     = 32;           // coordinate width, Q16.16
    localparam int FB     = 16;           // fraction bits
    localparam int TOL_W  = 16;
    localparam int QB     = CB + 2;       // quotient bits kept before saturation is certain
    localparam int DIFF_W = CB + 1;
    localparam int PD_W   = 2 * CB;       // n*d product
    localparam int PN_W   = 2 * CB + 1;   // n*(p-l) product
    localparam int DENS_W = 2 * CB + 1;   // signed denominator
    localparam int NUMS_W = 2 * CB + 2;   // signed numerator
    localparam int DEN_W  = 2 * CB;       // denominator magnitude
    localparam int NM_W   = 2 * CB + 1;   // numerator magnitude
    localparam int LO_W   = CB + 1;
    localparam int HI_W   = NM_W - LO_W;
    localparam int P_W    = 3 * CB;       // |d| * |num|
    localparam int CMP_W  = DEN_W + QB;
    localparam int SUM_W  = QB + 3;
    localparam int NFRONT = 8;

    typedef struct packed {
        logic signed [CB-1:0] line_x;
        logic signed [CB-1:0] line_y;
        logic signed [CB-1:0] line_z;
        logic signed [CB-1:0] dir_x;
        logic signed [CB-1:0] dir_y;
        logic signed [CB-1:0] dir_z;
        logic signed [CB-1:0] plane_x;
        logic signed [CB-1:0] plane_y;
        logic signed [CB-1:0] normal_x;
        logic signed [CB-1:0] normal_y;
    } t_in_word;

    typedef struct packed {
        logic                 found;
        logic signed [CB-1:0] hit_x;
        logic signed [CB-1:0] hit_y;
        logic signed [CB-1:0] hit_z;
    } t_out_word;

    typedef struct packed {
        logic [DEN_W-1:0]     rem;
        logic [QB-1:0]        pbits;
        logic [QB-1:0]        quo;
        logic                 big;
        logic                 qneg;
        logic signed [CB-1:0] base;
    } t_lane;

    typedef struct packed {
        logic             special;
        logic [DEN_W-1:0] den;
        t_lane [2:0]      lane;
    } t_div_word;

    function automatic logic [CB-1:0] mag(logic signed [CB-1:0] v);
        return v[CB-1] ? CB'(-v) : CB'(v);
    endfunction

    // one restoring step: shift in the next dividend bit, subtract if it fits
    function automatic t_lane lane_step(t_lane a, logic [DEN_W-1:0] den);
        logic [DEN_W:0] t;
        t_lane r;
        r = a;
        t = {a.rem, a.pbits[QB-1]};
        r.pbits = {a.pbits[QB-2:0], 1'b0};
        if (t >= {1'b0, den}) begin
            r.rem = DEN_W'(t - {1'b0, den});
            r.quo = {a.quo[QB-2:0], 1'b1};
        end else begin
            r.rem = t[DEN_W-1:0];
            r.quo = {a.quo[QB-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic t_div_word div_step(t_div_word a);
        t_div_word r;
        r = a;
        for (int k = 0; k < 3; k++) begin
            r.lane[k] = lane_step(a.lane[k], a.den);
        end
        return r;
    endfunction

endpackage

### rtl/line_vertical_plane_intersect.sv
`timescale 1ns / 1ps
// channel | direction | handshake               | word
// in      | input     | i_in_valid / o_in_stall | i_in_word  (t_in_word)
// out     | output    | o_out_valid / i_out_stall | o_out_word (t_out_word)
// cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_data (zero tolerance)
//
// One word per cycle while the output is not stalled; 8 front stages
// (differences, products, sums, tests, partial products), 34 restoring
// divide stages (one quotient bit each, three coordinates in parallel) and 2
// for rounding and saturation. Reset is synchronous and empties the pipeline;
// the tolerance returns to 1. A stall holds the output word; bubbles still
// close up, so o_in_stall rises only once every stage holds a word.
module line_vertical_plane_intersect import lvpi_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_word         i_in_word,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_word        o_out_word,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [TOL_W-1:0] i_cfg_data
);

    logic [TOL_W-1:0] r_tol;
    logic      f_ready, f_valid, d_ready, d_valid, b_ready;
    t_div_word f_word, d_word;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = !f_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_tol <= i_cfg_data;
        end
    end

    lvpi_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (f_ready),
        .i_word  (i_in_word),
        .i_tol   (r_tol),
        .o_valid (f_valid),
        .i_ready (d_ready),
        .o_word  (f_word)
    );

    lvpi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (d_ready),
        .i_word  (f_word),
        .o_valid (d_valid),
        .i_ready (b_ready),
        .o_word  (d_word)
    );

    lvpi_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (d_valid),
        .o_ready (b_ready),
        .i_word  (d_word),
        .o_valid (o_out_valid),
        .i_ready (!i_out_stall),
        .o_word  (o_out_word)
    );

endmodule

### rtl/lvpi_front.sv
`timescale 1ns / 1ps
module lvpi_front import lvpi_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_in_word         i_word,
    input  logic [TOL_W-1:0] i_tol,
    output logic             o_valid,
    input  logic             i_ready,
    output t_div_word        o_word
);

    typedef struct packed {
        t_in_word         w;
        logic [TOL_W-1:0] tol;
    } t_s1;

    typedef struct packed {
        logic signed [DIFF_W-1:0] ex;
        logic signed [DIFF_W-1:0] ey;
        logic                     flag;
        logic [TOL_W-1:0]         tol;
        logic signed [CB-1:0]     lx, ly, lz, dx, dy, dz, nx, ny;
    } t_s2;

    typedef struct packed {
        logic signed [PD_W-1:0] pdx, pdy;
        logic signed [PN_W-1:0] pnx, pny;
        logic                   flag;
        logic [TOL_W-1:0]       tol;
        logic signed [CB-1:0]   lx, ly, lz, dx, dy, dz;
    } t_s3;

    typedef struct packed {
        logic signed [DENS_W-1:0] den;
        logic signed [NUMS_W-1:0] num;
        logic                     flag;
        logic [TOL_W-1:0]         tol;
        logic signed [CB-1:0]     lx, ly, lz, dx, dy, dz;
    } t_s4;

    typedef struct packed {
        logic                 special;
        logic [DEN_W-1:0]     den;
        logic [NM_W-1:0]      nmag;
        logic [2:0][CB-1:0]   dmag;
        logic [2:0]           qneg;
        logic [2:0][CB-1:0]   base;
    } t_s5;

    typedef struct packed {
        logic                       special;
        logic [DEN_W-1:0]           den;
        logic [2:0][CB+LO_W-1:0]    lo;
        logic [2:0][CB+HI_W-1:0]    hi;
        logic [2:0]                 qneg;
        logic [2:0][CB-1:0]         base;
    } t_s6;

    typedef struct packed {
        logic               special;
        logic [DEN_W-1:0]   den;
        logic [2:0][P_W-1:0] p;
        logic [2:0]         qneg;
        logic [2:0][CB-1:0] base;
    } t_s7;

    logic [NFRONT:1]   r_v;
    logic [NFRONT+1:1] en;
    t_s1 r_s1;
    t_s2 r_s2, n_s2;
    t_s3 r_s3, n_s3;
    t_s4 r_s4, n_s4;
    t_s5 r_s5, n_s5;
    t_s6 r_s6, n_s6;
    t_s7 r_s7, n_s7;
    t_div_word r_s8, n_s8;

    assign en[NFRONT+1] = i_ready;
    for (genvar g = 1; g <= NFRONT; g++) begin : g_en
        assign en[g] = !r_v[g] || en[g+1];
    end

    assign o_ready = en[1];
    assign o_valid = r_v[NFRONT];
    assign o_word  = r_s8;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[1]) r_v[1] <= i_valid;
            for (int i = 2; i <= NFRONT; i++) begin
                if (en[i]) r_v[i] <= r_v[i-1];
            end
        end
    end

    // differences and the direction / normal degeneracy tests
    always_comb begin
        logic [CB-1:0] tl;
        tl = {{(CB-TOL_W){1'b0}}, r_s1.tol};
        n_s2.ex   = DIFF_W'(r_s1.w.plane_x) - DIFF_W'(r_s1.w.line_x);
        n_s2.ey   = DIFF_W'(r_s1.w.plane_y) - DIFF_W'(r_s1.w.line_y);
        n_s2.flag = (mag(r_s1.w.normal_x) < tl && mag(r_s1.w.normal_y) < tl) ||
                    (mag(r_s1.w.dir_x) < tl && mag(r_s1.w.dir_y) < tl);
        n_s2.tol  = r_s1.tol;
        n_s2.lx   = r_s1.w.line_x;
        n_s2.ly   = r_s1.w.line_y;
        n_s2.lz   = r_s1.w.line_z;
        n_s2.dx   = r_s1.w.dir_x;
        n_s2.dy   = r_s1.w.dir_y;
        n_s2.dz   = r_s1.w.dir_z;
        n_s2.nx   = r_s1.w.normal_x;
        n_s2.ny   = r_s1.w.normal_y;
    end

    always_comb begin
        n_s3.pdx  = r_s2.nx * r_s2.dx;
        n_s3.pdy  = r_s2.ny * r_s2.dy;
        n_s3.pnx  = PN_W'(r_s2.nx) * PN_W'(r_s2.ex);
        n_s3.pny  = PN_W'(r_s2.ny) * PN_W'(r_s2.ey);
        n_s3.flag = r_s2.flag;
        n_s3.tol  = r_s2.tol;
        n_s3.lx   = r_s2.lx;
        n_s3.ly   = r_s2.ly;
        n_s3.lz   = r_s2.lz;
        n_s3.dx   = r_s2.dx;
        n_s3.dy   = r_s2.dy;
        n_s3.dz   = r_s2.dz;
    end

    always_comb begin
        n_s4.den  = DENS_W'(r_s3.pdx) + DENS_W'(r_s3.pdy);
        n_s4.num  = NUMS_W'(r_s3.pnx) + NUMS_W'(r_s3.pny);
        n_s4.flag = r_s3.flag;
        n_s4.tol  = r_s3.tol;
        n_s4.lx   = r_s3.lx;
        n_s4.ly   = r_s3.ly;
        n_s4.lz   = r_s3.lz;
        n_s4.dx   = r_s3.dx;
        n_s4.dy   = r_s3.dy;
        n_s4.dz   = r_s3.dz;
    end

    // magnitudes, quotient signs and the parallel-line test
    always_comb begin
        logic dneg;
        logic nneg;
        logic [DEN_W-1:0] dm;
        dneg = r_s4.den[DENS_W-1];
        nneg = r_s4.num[NUMS_W-1];
        dm   = dneg ? DEN_W'(-r_s4.den) : DEN_W'(r_s4.den);
        n_s5.den  = dm;
        n_s5.nmag = nneg ? NM_W'(-r_s4.num) : NM_W'(r_s4.num);
        n_s5.special = r_s4.flag || (dm == '0) ||
                       (dm < {{(DEN_W-TOL_W-FB){1'b0}}, r_s4.tol, {FB{1'b0}}});
        n_s5.dmag[0] = mag(r_s4.dx);
        n_s5.dmag[1] = mag(r_s4.dy);
        n_s5.dmag[2] = mag(r_s4.dz);
        n_s5.qneg[0] = r_s4.dx[CB-1] ^ nneg ^ dneg;
        n_s5.qneg[1] = r_s4.dy[CB-1] ^ nneg ^ dneg;
        n_s5.qneg[2] = r_s4.dz[CB-1] ^ nneg ^ dneg;
        n_s5.base[0] = r_s4.lx;
        n_s5.base[1] = r_s4.ly;
        n_s5.base[2] = r_s4.lz;
    end

    // |d| * |num| as two partial products
    always_comb begin
        n_s6.special = r_s5.special;
        n_s6.den     = r_s5.den;
        n_s6.qneg    = r_s5.qneg;
        n_s6.base    = r_s5.base;
        for (int k = 0; k < 3; k++) begin
            n_s6.lo[k] = (CB+LO_W)'(r_s5.dmag[k]) * (CB+LO_W)'(r_s5.nmag[LO_W-1:0]);
            n_s6.hi[k] = (CB+HI_W)'(r_s5.dmag[k]) * (CB+HI_W)'(r_s5.nmag[NM_W-1:LO_W]);
        end
    end

    always_comb begin
        n_s7.special = r_s6.special;
        n_s7.den     = r_s6.den;
        n_s7.qneg    = r_s6.qneg;
        n_s7.base    = r_s6.base;
        for (int k = 0; k < 3; k++) begin
            n_s7.p[k] = P_W'(r_s6.lo[k]) + (P_W'(r_s6.hi[k]) << LO_W);
        end
    end

    // quotient too large to keep: the result saturates
    always_comb begin
        n_s8.special = r_s7.special;
        n_s8.den     = r_s7.den;
        for (int k = 0; k < 3; k++) begin
            n_s8.lane[k].big   = {{(CMP_W-P_W){1'b0}}, r_s7.p[k]} >=
                                 {r_s7.den, {QB{1'b0}}};
            n_s8.lane[k].rem   = DEN_W'(r_s7.p[k][P_W-1:QB]);
            n_s8.lane[k].pbits = r_s7.p[k][QB-1:0];
            n_s8.lane[k].quo   = '0;
            n_s8.lane[k].qneg  = r_s7.qneg[k];
            n_s8.lane[k].base  = r_s7.base[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_s1.w   <= i_word;
            r_s1.tol <= i_tol;
        end
        if (en[2]) r_s2 <= n_s2;
        if (en[3]) r_s3 <= n_s3;
        if (en[4]) r_s4 <= n_s4;
        if (en[5]) r_s5 <= n_s5;
        if (en[6]) r_s6 <= n_s6;
        if (en[7]) r_s7 <= n_s7;
        if (en[8]) r_s8 <= n_s8;
    end

endmodule

### rtl/lvpi_div.sv
`timescale 1ns / 1ps
module lvpi_div import lvpi_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_div_word i_word,
    output logic      o_valid,
    input  logic      i_ready,
    output t_div_word o_word
);

    logic [QB-1:0] r_v;
    logic [QB:0]   en;
    t_div_word     r_d [QB];

    assign en[QB] = i_ready;
    for (genvar g = 0; g < QB; g++) begin : g_en
        assign en[g] = !r_v[g] || en[g+1];
    end

    assign o_ready = en[0];
    assign o_valid = r_v[QB-1];
    assign o_word  = r_d[QB-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            for (int i = 1; i < QB; i++) begin
                if (en[i]) r_v[i] <= r_v[i-1];
            end
        end
    end

    // one quotient bit per stage, all three lanes side by side
    always_ff @(posedge i_clk) begin
        if (en[0]) r_d[0] <= div_step(i_word);
        for (int i = 1; i < QB; i++) begin
            if (en[i]) r_d[i] <= div_step(r_d[i-1]);
        end
    end

endmodule

### rtl/lvpi_back.sv
`timescale 1ns / 1ps
module lvpi_back import lvpi_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_div_word i_word,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_word
);

    localparam logic signed [CB-1:0] MAXC = {1'b0, {(CB-1){1'b1}}};
    localparam logic signed [CB-1:0] MINC = {1'b1, {(CB-1){1'b0}}};

    typedef struct packed {
        logic               special;
        logic [2:0]         big;
        logic [2:0]         qneg;
        logic [2:0][CB-1:0] base;
        logic [2:0][QB:0]   qr;
    } t_b1;

    logic      r_v1, r_v2;
    logic      en1, en2;
    t_b1       r_b1, n_b1;
    t_out_word r_out, n_out;
    logic [2:0][CB-1:0] hit;

    assign en2     = !r_v2 || i_ready;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;
    assign o_valid = r_v2;
    assign o_word  = r_out;

    // round to nearest, ties away from zero
    always_comb begin
        n_b1.special = i_word.special;
        for (int k = 0; k < 3; k++) begin
            n_b1.big[k]  = i_word.lane[k].big;
            n_b1.qneg[k] = i_word.lane[k].qneg;
            n_b1.base[k] = i_word.lane[k].base;
            n_b1.qr[k]   = (QB+1)'(i_word.lane[k].quo) +
                           (QB+1)'({i_word.lane[k].rem, 1'b0} >= {1'b0, i_word.den});
        end
    end

    always_comb begin
        logic signed [SUM_W-1:0] qs;
        logic signed [SUM_W-1:0] sum;
        for (int k = 0; k < 3; k++) begin
            qs  = $signed({2'b00, r_b1.qr[k]});
            if (r_b1.qneg[k]) qs = -qs;
            sum = SUM_W'($signed(r_b1.base[k])) + qs;
            if (r_b1.big[k]) begin
                hit[k] = r_b1.qneg[k] ? MINC : MAXC;
            end else if (sum > SUM_W'(MAXC)) begin
                hit[k] = MAXC;
            end else if (sum < SUM_W'(MINC)) begin
                hit[k] = MINC;
            end else begin
                hit[k] = sum[CB-1:0];
            end
        end
        n_out.found = !r_b1.special;
        n_out.hit_x = r_b1.special ? '0 : hit[0];
        n_out.hit_y = r_b1.special ? '0 : hit[1];
        n_out.hit_z = r_b1.special ? '0 : hit[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) r_b1  <= n_b1;
        if (en2) r_out <= n_out;
    end

endmodule

### rtl/lvpi_checker.sv
`timescale 1ns / 1ps
module lvpi_checker import lvpi_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_word o_out_word
);

    // a stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("output word changed under stall");

    // no intersection reads as all zero
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.found |->
            o_out_word.hit_x == '0 && o_out_word.hit_y == '0 && o_out_word.hit_z == '0)
        else $error("hit coordinates set without found");

    // input backs up only when the output is blocked
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled with free output");

    // reset empties the pipeline
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind line_vertical_plane_intersect lvpi_checker u_lvpi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

### sim/line_vertical_plane_intersect_test.sv
`timescale 1ns / 1ps
module line_vertical_plane_intersect_test;
    import lvpi_pkg::*;

    localparam logic signed [CB-1:0] ONE  = 32'sh0001_0000;
    localparam logic signed [CB-1:0] CMAX = 32'sh7fff_ffff;
    localparam logic signed [CB-1:0] CMIN = 32'sh8000_0000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct {
        t_in_word  w;
        bit        typed;
        t_out_word want;
    } t_row;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_stall;
    t_in_word         i_in_word;
    logic             o_out_valid;
    logic             i_out_stall;
    t_out_word        o_out_word;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [TOL_W-1:0] i_cfg_data;

    t_out_word        pending_hits[$];
    logic [TOL_W-1:0] tolerance;
    int               send_idle_pct;
    int               recv_stall_pct;
    int               mismatches;
    int               words_checked;
    int               found_count;
    t_row             rows[$];

    line_vertical_plane_intersect DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic signed [127:0] abs128(logic signed [127:0] v);
        return v < 0 ? -v : v;
    endfunction

    function automatic t_out_word hit_point(t_in_word w, logic [TOL_W-1:0] tol);
        logic signed [127:0] lv[3], dv[3];
        logic signed [127:0] nx, ny, px, py, den, num, p, q, s;
        logic signed [127:0] pm, dm, lim;
        logic signed [CB-1:0] hc[3];
        t_out_word r;
        lv[0] = 128'(w.line_x); lv[1] = 128'(w.line_y); lv[2] = 128'(w.line_z);
        dv[0] = 128'(w.dir_x);  dv[1] = 128'(w.dir_y);  dv[2] = 128'(w.dir_z);
        nx = 128'(w.normal_x); ny = 128'(w.normal_y);
        px = 128'(w.plane_x);  py = 128'(w.plane_y);
        lim = 128'(tol);
        r = '0;
        if (abs128(nx) < lim && abs128(ny) < lim) return r;
        if (abs128(dv[0]) < lim && abs128(dv[1]) < lim) return r;
        den = nx * dv[0] + ny * dv[1];
        if (den == 0 || abs128(den) < (lim <<< 16)) return r;
        num = nx * (px - lv[0]) + ny * (py - lv[1]);
        dm = abs128(den);
        for (int k = 0; k < 3; k++) begin
            p  = dv[k] * num;
            pm = abs128(p);
            q  = (2 * pm + dm) / (2 * dm);
            if ((p < 0) != (den < 0)) q = -q;
            s = lv[k] + q;
            if (s > 128'sh7fff_ffff) hc[k] = CMAX;
            else if (s < -128'sh8000_0000) hc[k] = CMIN;
            else hc[k] = s[CB-1:0];
        end
        r.found = 1'b1;
        r.hit_x = hc[0]; r.hit_y = hc[1]; r.hit_z = hc[2];
        return r;
    endfunction

    function automatic logic signed [CB-1:0] rnd_coord();
        case ($urandom_range(4))
            0, 1: return $urandom;
            2: return $signed(32'($urandom_range(140000))) - 70000;
            3: return $signed(32'($urandom_range(1 << 21))) - (1 << 20);
            default: case ($urandom_range(3))
                0: return CMAX;
                1: return CMIN;
                2: return '0;
                default: return -1;
            endcase
        endcase
    endfunction

    function automatic t_in_word rnd_word();
        t_in_word w;
        w.line_x = rnd_coord(); w.line_y = rnd_coord(); w.line_z = rnd_coord();
        w.dir_x = rnd_coord();  w.dir_y = rnd_coord();  w.dir_z = rnd_coord();
        w.plane_x = rnd_coord(); w.plane_y = rnd_coord();
        w.normal_x = rnd_coord(); w.normal_y = rnd_coord();
        // steer toward a parallel or nearly parallel direction
        if ($urandom_range(4) == 0) begin
            w.dir_x = -w.normal_y + $signed(32'($urandom_range(8))) - 4;
            w.dir_y = w.normal_x + $signed(32'($urandom_range(8))) - 4;
        end
        return w;
    endfunction

    function automatic t_in_word mk(logic signed [CB-1:0] lx, ly, lz, dx, dy, dz,
                                    px, py, nx, ny);
        t_in_word w;
        w.line_x = lx; w.line_y = ly; w.line_z = lz;
        w.dir_x = dx;  w.dir_y = dy;  w.dir_z = dz;
        w.plane_x = px; w.plane_y = py; w.normal_x = nx; w.normal_y = ny;
        return w;
    endfunction

    task automatic add_row(t_in_word w, bit typed, t_out_word want);
        t_row r;
        r.w = w; r.typed = typed; r.want = want;
        rows.push_back(r);
    endtask

    task automatic send_word(t_in_word w, bit typed, t_out_word want);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        pending_hits.push_back(typed ? want : hit_point(w, tolerance));
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_hits.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_tolerance(logic [TOL_W-1:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        tolerance = v;
    endtask

    // output side: check each accepted word, then pick the next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_hits.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %p", o_out_word);
            end else begin
                t_out_word want;
                want = pending_hits.pop_front();
                words_checked++;
                if (want.found) found_count++;
                if (o_out_word.found !== want.found || o_out_word.hit_x !== want.hit_x
                    || o_out_word.hit_y !== want.hit_y
                    || o_out_word.hit_z !== want.hit_z) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p got %p", want, o_out_word);
                end
            end
        end
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    initial begin
        logic [TOL_W-1:0] tol_plan[4];
        int idle_plan[4], stall_plan[4];
        t_out_word none, hit2;
        i_rst_n = 1'b0; i_in_valid = 1'b0; i_in_word = '0; i_out_stall = 1'b0;
        i_cfg_valid = 1'b0; i_cfg_data = '0;
        tolerance = TOL_W'(1); send_idle_pct = 0; recv_stall_pct = 0;
        mismatches = 0; words_checked = 0; found_count = 0;
        none = '0;
        hit2 = '{1'b1, 2 * ONE, 2 * ONE, 2 * ONE};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_row(mk(ONE, ONE, ONE, ONE, ONE, ONE, 0, 0, 0, 0), 1'b1, none);      // zero normal
        add_row(mk(ONE, ONE, ONE, 0, 0, 0, ONE, 0, ONE, 0), 1'b1, none);        // zero direction
        add_row(mk(0, 0, 0, 0, 0, ONE, ONE, 0, ONE, ONE), 1'b1, none);          // vertical line
        add_row(mk(0, 0, 0, 0, ONE, ONE, 2 * ONE, 0, ONE, 0), 1'b1, none);      // parallel
        add_row(mk(2 * ONE, 0, 0, 0, ONE, 0, 2 * ONE, 0, ONE, 0), 1'b1, none);  // in plane
        add_row(mk(0, 0, 0, ONE, ONE, ONE, 2 * ONE, 0, ONE, 0), 1'b1, hit2);
        add_row(mk(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX), 1'b0, none);
        add_row(mk(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN), 1'b0, none);
        add_row(mk(CMIN, CMAX, CMIN, 1, 0, CMAX, CMAX, 0, CMAX, 0), 1'b0, none);
        add_row(mk(CMAX, CMIN, 0, 1, 1, CMIN, CMIN, CMAX, CMIN, CMAX), 1'b0, none);
        add_row(mk(0, 0, 0, 2, 0, 1, 1, 0, ONE, 0), 1'b0, none);                // rounding tie
        add_row(mk(0, 0, 0, -2, 0, 3, -1, 0, ONE, 0), 1'b0, none);
        add_row(mk(ONE, -ONE, 5, 1, 0, -1, 0, 0, 0, 1), 1'b0, none);            // tiny values
        add_row(mk(0, 0, 0, -1, -1, -1, 3, 3, -1, -1), 1'b0, none);
        foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].want);

        tol_plan   = '{16'd0, 16'hffff, 16'($urandom), 16'd1};
        idle_plan  = '{0, 62, 0, 34};
        stall_plan = '{0, 0, 62, 34};
        for (int ph = 0; ph < 4; ph++) begin
            write_tolerance(tol_plan[ph]);
            send_idle_pct  = idle_plan[ph];
            recv_stall_pct = stall_plan[ph];
            for (int n = 0; n < 210; n++) begin
                if (ph == 2 && n == 105) drain();   // hold until every word is back
                send_word(rnd_word(), 1'b0, none);
            end
        end
        drain();
        $display("checked %0d words (%0d with an intersection) over tolerances 1, 0, max,",
                 words_checked, found_count);
        $display("a random one and 1 again, under sender gaps and receiver stalls");
        if (mismatches == 0 && pending_hits.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

### filelist.f
rtl/lvpi_pkg.sv
rtl/lvpi_front.sv
rtl/lvpi_div.sv
rtl/lvpi_back.sv
rtl/line_vertical_plane_intersect.sv
rtl/lvpi_checker.sv
sim/line_vertical_plane_intersect_test.sv
